FILE: rtl/core/lbfs_pkg.sv
// lbfs_pkg: shared widths, constants and state codes of the frequency selector
// no dependencies; imported by every module of the core

package lbfs_pkg;

    // field widths
    localparam int FREQ_W   = 22;
    localparam int LOAD_W   = 7;
    localparam int DELTA_W  = 32;
    localparam int TLEN_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W  = FREQ_W + 1;

    // floor(x / 100) for x < 2^22 as (x * RECIP_100) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
    localparam int MAXDIV_W    = 16;

    // percent scale
    localparam logic [LOAD_W-1:0] PERCENT = 7'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN = 2'd2;

    // item kinds
    localparam logic REQ_TABLE_WRITE = 1'b0;
    localparam logic REQ_SAMPLE      = 1'b1;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TWR   = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_SCALE = 8'b0001_0000,
        S_CLAMP = 8'b0010_0000,
        S_WALK  = 8'b0100_0000,
        S_PICK  = 8'b1000_0000
    } t_state;

    // frequency table entry
    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] freq;
    } t_entry;

endpackage

FILE: rtl/core/lbfs_table_mem.sv
// lbfs_table_mem: frequency table, one write port and one registered read port
// depends on lbfs_pkg for the entry type

module lbfs_table_mem
    import lbfs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lbfs_load_div.sv
// lbfs_load_div: busy percentage, 100*busy/wall by restoring division
// depends on lbfs_pkg for widths; one quotient bit per cycle, 7 steps

module lbfs_load_div
    import lbfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELTA_W-1:0] i_busy,
    input  logic [DELTA_W-1:0] i_wall,
    output logic               o_done,
    output logic [LOAD_W-1:0]  o_load
);

    localparam int NUM_W = DELTA_W + LOAD_W;
    localparam int DSR_W = DELTA_W + LOAD_W - 1;

    logic [NUM_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [LOAD_W-1:0] r_q;
    logic [2:0]        r_cnt;
    logic              r_run;
    logic              r_done;
    logic              w_ge;

    // current divisor weight fits under the remainder
    assign w_ge = (r_rem >= {1'b0, r_dsr});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 3'(LOAD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: product loaded once, then one compare and subtract a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= NUM_W'(i_busy) * NUM_W'(PERCENT);
            r_dsr <= {i_wall, {(LOAD_W-1){1'b0}}};
            r_q   <= '0;
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= r_rem - {1'b0, r_dsr};
            end
            r_dsr <= r_dsr >> 1;
            r_q   <= {r_q[LOAD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_load = r_q;

endmodule

FILE: rtl/core/load_based_frequency_selector_core.sv
// load_based_frequency_selector_core: top level, sequencer, table walk and outputs
// depends on lbfs_pkg, lbfs_table_mem and lbfs_load_div
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  item in   | start, busy (accept when  | i_req_type, i_entry_index, i_entry_freq_khz,
//            | start high, busy low)     | i_entry_valid, i_total_wall_time,
//            |                           | i_total_idle_time, i_current_freq_khz
//  result    | o_done, one cycle strobe  | o_load_valid, o_load_percent,
//            |                           | o_change_request, o_target_freq_khz
//  config    | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A table write passes through S_TWR before the result strobe; a skipped sample
// leaves from S_CHECK. A full sample runs S_CHECK, S_DIV, S_SCALE, S_CLAMP, S_WALK
// and S_PICK; S_DIV holds the 7-step load divider and S_WALK reads the table, one
// entry a cycle up to its length capped at TABLE_DEPTH. Synchronous
// active-low reset clears control, configuration and the previous totals; the
// table holds no reset and has no clearing pass. The result receiver cannot
// stall; config is always ready.

module load_based_frequency_selector_core
    import lbfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item in
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_req_type,
    input  logic [3:0]           i_entry_index,
    input  logic [FREQ_W-1:0]    i_entry_freq_khz,
    input  logic                 i_entry_valid,
    input  logic [63:0]          i_total_wall_time,
    input  logic [63:0]          i_total_idle_time,
    input  logic [FREQ_W-1:0]    i_current_freq_khz,
    // result
    output logic                 o_done,
    output logic                 o_load_valid,
    output logic [LOAD_W-1:0]    o_load_percent,
    output logic                 o_change_request,
    output logic [FREQ_W-1:0]    o_target_freq_khz,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FREQ_W-1:0]    i_cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MPROD_W = FREQ_W + RECIP_W;

    t_state r_state, n_state;

    // configuration registers
    logic [FREQ_W-1:0]   r_min_freq;
    logic [FREQ_W-1:0]   r_max_freq;
    logic [TLEN_W-1:0]   r_table_len;
    logic [MAXDIV_W-1:0] r_max_div;
    logic [MPROD_W-1:0]  w_mprod;

    // item and sample registers
    logic [3:0]          r_entry_index;
    t_entry              r_entry;
    logic [DELTA_W-1:0]  r_last_wall;
    logic [DELTA_W-1:0]  r_last_idle;
    logic [DELTA_W-1:0]  r_wall;
    logic [DELTA_W-1:0]  r_idle;
    logic [FREQ_W-1:0]   r_cur;
    logic [LOAD_W-1:0]   r_load;
    logic [FREQ_W-1:0]   r_raw;
    logic [FREQ_W+LOAD_W-1:0] w_scaled;

    // walk registers
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_pend;
    logic [FREQ_W-1:0]   r_below;
    logic [FREQ_W-1:0]   r_above;
    logic [FREQ_W-1:0]   r_chosen;
    logic [CNT_W-1:0]    w_len;
    logic                w_issue;
    logic                w_hit;
    logic                w_walk_end;

    // result registers
    logic                r_done;
    logic                r_load_valid;
    logic [LOAD_W-1:0]   r_load_percent;
    logic                r_change;
    logic [FREQ_W-1:0]   r_target;
    logic [FREQ_W-1:0]   w_pick;

    // memory and divider hookup
    logic                w_we;
    t_entry              w_rdata;
    logic                w_div_start;
    logic                w_div_done;
    logic [LOAD_W-1:0]   w_div_load;
    logic                w_accept;
    logic                w_skip;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration writes and the max/100 scale factor
    assign w_mprod = MPROD_W'(r_max_freq) * MPROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq  <= '0;
            r_max_freq  <= '1;
            r_table_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_FREQ:  r_min_freq  <= i_cfg_data;
                CFG_MAX_FREQ:  r_max_freq  <= i_cfg_data;
                CFG_TABLE_LEN: r_table_len <= i_cfg_data[TLEN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_div <= w_mprod[RECIP_SHIFT +: MAXDIV_W];
    end

    // table memory
    assign w_we = (r_state == S_TWR) && (32'(r_entry_index) < TABLE_DEPTH);

    lbfs_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(r_entry_index)),
        .i_wdata (r_entry),
        .i_re    (w_issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // load divider
    assign w_skip      = (r_wall == '0) || (r_wall < r_idle);
    assign w_div_start = (r_state == S_CHECK) && !w_skip;

    lbfs_load_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_busy  (r_wall - r_idle),
        .i_wall  (r_wall),
        .o_done  (w_div_done),
        .o_load  (w_div_load)
    );

    // walk control: one read issued a cycle, its registered data checked in the next
    assign w_len      = (32'(r_table_len) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(r_table_len);
    assign w_issue    = (r_state == S_WALK) && (r_rd_idx < w_len);
    assign w_hit      = r_pend && w_rdata.valid && (w_rdata.freq >= r_raw);
    assign w_walk_end = w_hit || (!r_pend && (r_rd_idx >= w_len));

    // final choice: the exact match if one was found, else current or the entry above
    always_comb begin
        if (r_chosen != '0) begin
            w_pick = r_chosen;
        end else if ((r_cur >= r_below) && (r_cur <= r_above)) begin
            w_pick = r_cur;
        end else begin
            w_pick = r_above;
        end
    end

    assign w_scaled = (FREQ_W+LOAD_W)'(r_load) * (FREQ_W+LOAD_W)'(r_max_div);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req_type == REQ_SAMPLE) ? S_CHECK : S_TWR;
                end
            end
            S_TWR:   n_state = S_IDLE;
            S_CHECK: n_state = w_skip ? S_IDLE : S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_CLAMP;
            S_CLAMP: n_state = S_WALK;
            S_WALK: begin
                if (w_walk_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // previous totals, only the low word feeds the wrapped deltas
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_wall <= '0;
            r_last_idle <= '0;
        end else if (w_accept && (i_req_type == REQ_SAMPLE)) begin
            r_last_wall <= i_total_wall_time[DELTA_W-1:0];
            r_last_idle <= i_total_idle_time[DELTA_W-1:0];
        end
    end

    // item capture and sample datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry_index <= i_entry_index;
            r_entry.valid <= i_entry_valid;
            r_entry.freq  <= i_entry_freq_khz;
            r_wall        <= i_total_wall_time[DELTA_W-1:0] - r_last_wall;
            r_idle        <= i_total_idle_time[DELTA_W-1:0] - r_last_idle;
            r_cur         <= i_current_freq_khz;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_load <= w_div_load;
        end
        // raw target, then clamp to min first and max last
        if (r_state == S_SCALE) begin
            r_raw <= w_scaled[FREQ_W-1:0];
        end
        if (r_state == S_CLAMP) begin
            if (r_raw < r_min_freq) begin
                r_raw <= (r_min_freq > r_max_freq) ? r_max_freq : r_min_freq;
            end else if (r_raw > r_max_freq) begin
                r_raw <= r_max_freq;
            end
        end
    end

    // table walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (r_state == S_CLAMP) begin
            r_pend <= 1'b0;
        end else if (r_state == S_WALK) begin
            r_pend <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLAMP) begin
            r_rd_idx <= '0;
            r_below  <= '0;
            r_above  <= '0;
            r_chosen <= '0;
        end else if (r_state == S_WALK) begin
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (r_pend && w_rdata.valid) begin
                if (w_rdata.freq < r_raw) begin
                    r_below <= w_rdata.freq;
                end else if (w_rdata.freq == r_raw) begin
                    r_chosen <= w_rdata.freq;
                end else begin
                    r_above <= w_rdata.freq;
                end
            end
        end
    end

    // result register, one strobe per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_TWR) || ((r_state == S_CHECK) && w_skip)
                      || (r_state == S_PICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PICK) begin
            r_load_valid   <= 1'b1;
            r_load_percent <= r_load;
            r_change       <= (w_pick != r_cur) && (w_pick != '0);
            r_target       <= w_pick;
        end else begin
            r_load_valid   <= 1'b0;
            r_load_percent <= '0;
            r_change       <= 1'b0;
            r_target       <= '0;
        end
    end

    assign o_done            = r_done;
    assign o_load_valid      = r_load_valid;
    assign o_load_percent    = r_load_percent;
    assign o_change_request  = r_change;
    assign o_target_freq_khz = r_target;

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for the load based frequency selector core
// depends on lbfs_pkg and load_based_frequency_selector_core; drives items and
// config writes, predicts each result and compares it with the result strobe
`timescale 1ns / 1ps

module testbench;
    import lbfs_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 3000;
    localparam logic [FREQ_W-1:0] FREQ_TOP = '1;

    // one input item and one result
    typedef struct packed {
        logic              req_type;
        logic [3:0]        entry_index;
        logic [FREQ_W-1:0] entry_freq;
        logic              entry_valid;
        logic [63:0]       wall_total;
        logic [63:0]       idle_total;
        logic [FREQ_W-1:0] cur_freq;
    } gov_item_t;

    typedef struct packed {
        logic              load_valid;
        logic [LOAD_W-1:0] load_percent;
        logic              change_request;
        logic [FREQ_W-1:0] chosen_khz;
    } selection_t;

    // block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_req_type = REQ_TABLE_WRITE;
    logic [3:0]           i_entry_index = '0;
    logic [FREQ_W-1:0]    i_entry_freq_khz = '0;
    logic                 i_entry_valid = 1'b0;
    logic [63:0]          i_total_wall_time = '0;
    logic [63:0]          i_total_idle_time = '0;
    logic [FREQ_W-1:0]    i_current_freq_khz = '0;
    logic                 o_done;
    logic                 o_load_valid;
    logic [LOAD_W-1:0]    o_load_percent;
    logic                 o_change_request;
    logic [FREQ_W-1:0]    o_target_freq_khz;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MIN_FREQ;
    logic [FREQ_W-1:0]    i_cfg_data = '0;

    // predicted block state, starting from reset values
    logic [FREQ_W-1:0] lim_min = '0;
    logic [FREQ_W-1:0] lim_max = FREQ_TOP;
    logic [TLEN_W-1:0] walk_len = '0;
    logic [63:0]       prev_wall = '0;
    logic [63:0]       prev_idle = '0;
    logic [FREQ_W-1:0] tbl_freq [DEPTH];
    logic              tbl_valid [DEPTH];

    // stimulus planning state, ahead of what the block has taken
    logic [FREQ_W-1:0] plan_freq [DEPTH];
    logic [FREQ_W-1:0] plan_min = '0;
    logic [FREQ_W-1:0] plan_max = FREQ_TOP;
    logic [63:0]       wall_acc = '0;
    logic [63:0]       idle_acc = '0;

    gov_item_t   commands_waiting [$];
    selection_t  selections_due [$];
    gov_item_t   held;
    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    bit          calm = 1'b0;

    load_based_frequency_selector_core #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req_type(i_req_type),
        .i_entry_index(i_entry_index),
        .i_entry_freq_khz(i_entry_freq_khz),
        .i_entry_valid(i_entry_valid),
        .i_total_wall_time(i_total_wall_time),
        .i_total_idle_time(i_total_idle_time),
        .i_current_freq_khz(i_current_freq_khz),
        .o_done(o_done),
        .o_load_valid(o_load_valid),
        .o_load_percent(o_load_percent),
        .o_change_request(o_change_request),
        .o_target_freq_khz(o_target_freq_khz),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // governor step: update the table or the totals and pick a frequency
    function automatic selection_t govern(input gov_item_t it);
        selection_t        sel;
        logic [31:0]       dwall;
        logic [31:0]       didle;
        logic [31:0]       pct;
        logic [31:0]       raw;
        logic [63:0]       busy_x100;
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        logic [FREQ_W-1:0] pick;
        logic              stop;
        int unsigned       span;
        sel = '0;
        if (it.req_type == REQ_TABLE_WRITE) begin
            tbl_freq[it.entry_index] = it.entry_freq;
            tbl_valid[it.entry_index] = it.entry_valid;
            return sel;
        end
        dwall = 32'(it.wall_total - prev_wall);
        didle = 32'(it.idle_total - prev_idle);
        prev_wall = it.wall_total;
        prev_idle = it.idle_total;
        if (dwall == 0 || dwall < didle) begin
            return sel;
        end
        busy_x100 = 64'(dwall - didle) * 64'd100;
        pct = 32'(busy_x100 / 64'(dwall));
        raw = pct * (32'(lim_max) / 32'd100);
        if (raw < 32'(lim_min)) raw = 32'(lim_min);
        if (raw > 32'(lim_max)) raw = 32'(lim_max);
        span = (walk_len > DEPTH) ? DEPTH : walk_len;
        // ascending walk, stops at an exact match or the first entry above
        lo = '0;
        hi = '0;
        pick = '0;
        stop = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (!stop && k < span && tbl_valid[k]) begin
                if (32'(tbl_freq[k]) < raw) lo = tbl_freq[k];
                if (32'(tbl_freq[k]) == raw) begin
                    pick = tbl_freq[k];
                    stop = 1'b1;
                end else if (32'(tbl_freq[k]) > raw) begin
                    hi = tbl_freq[k];
                    stop = 1'b1;
                end
            end
        end
        // no match: keep current if it sits between the neighbors
        if (pick == '0) begin
            pick = (it.cur_freq >= lo && it.cur_freq <= hi) ? it.cur_freq : hi;
        end
        sel.load_valid = 1'b1;
        sel.load_percent = pct[LOAD_W-1:0];
        sel.change_request = (pick != it.cur_freq) && (pick != '0);
        sel.chosen_khz = pick;
        return sel;
    endfunction

    // item driver with random idle bursts
    always @(posedge i_clk) begin : drive_items
        gov_item_t nxt;
        logic      launch;
        if (i_rst_n) begin
            launch = 1'b0;
            if (start && !busy) begin
                selections_due.push_back(govern(held));
                if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 18);
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (commands_waiting.size() > 0) begin
                    nxt = commands_waiting.pop_front();
                    held = nxt;
                    i_req_type <= nxt.req_type;
                    i_entry_index <= nxt.entry_index;
                    i_entry_freq_khz <= nxt.entry_freq;
                    i_entry_valid <= nxt.entry_valid;
                    i_total_wall_time <= nxt.wall_total;
                    i_total_idle_time <= nxt.idle_total;
                    i_current_freq_khz <= nxt.cur_freq;
                    launch = 1'b1;
                end
                start <= launch;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        selection_t due;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (selections_due.size() == 0) begin
                $error("result strobe with no item outstanding");
                fail_count++;
            end else begin
                due = selections_due.pop_front();
                if (o_load_valid !== due.load_valid) begin
                    $error("load_valid expected %0d got %0d", due.load_valid, o_load_valid);
                    fail_count++;
                end
                if (o_load_percent !== due.load_percent) begin
                    $error("load_percent expected %0d got %0d",
                           due.load_percent, o_load_percent);
                    fail_count++;
                end
                if (o_change_request !== due.change_request) begin
                    $error("change_request expected %0d got %0d",
                           due.change_request, o_change_request);
                    fail_count++;
                end
                if (o_target_freq_khz !== due.chosen_khz) begin
                    $error("target_freq_khz expected %0d got %0d",
                           due.chosen_khz, o_target_freq_khz);
                    fail_count++;
                end
            end
        end
    end

    // cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // table write item, sample fields carry junk
    task automatic push_entry(input logic [3:0] slot, input logic [FREQ_W-1:0] freq,
                              input logic ok);
        gov_item_t it;
        it.req_type = REQ_TABLE_WRITE;
        it.entry_index = slot;
        it.entry_freq = freq;
        it.entry_valid = ok;
        it.wall_total = {$urandom, $urandom};
        it.idle_total = {$urandom, $urandom};
        it.cur_freq = FREQ_W'($urandom);
        plan_freq[slot] = freq;
        commands_waiting.push_back(it);
        items_queued++;
    endtask

    // sample item at the current totals, table fields carry junk
    task automatic push_interval(input logic [63:0] dwall, input logic [63:0] didle,
                                 input logic [FREQ_W-1:0] cur);
        gov_item_t it;
        wall_acc += dwall;
        idle_acc += didle;
        it.req_type = REQ_SAMPLE;
        it.entry_index = 4'($urandom);
        it.entry_freq = FREQ_W'($urandom);
        it.entry_valid = 1'($urandom);
        it.wall_total = wall_acc;
        it.idle_total = idle_acc;
        it.cur_freq = cur;
        commands_waiting.push_back(it);
        items_queued++;
    endtask

    // random well-formed interval, with some skipped and jumping samples
    task automatic push_random_sample();
        int unsigned       pick;
        int unsigned       dw;
        int unsigned       di;
        int unsigned       k;
        logic [FREQ_W-1:0] cur;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            dw = 0;
            di = $urandom_range(0, 50);
        end else if (pick < 10) begin
            dw = $urandom_range(1, 100000);
            di = dw + $urandom_range(1, 1000);
        end else if (pick < 14) begin
            wall_acc = {$urandom, $urandom};
            idle_acc = {$urandom, $urandom};
            dw = 0;
            di = 0;
        end else begin
            case ($urandom_range(0, 2))
                0: dw = $urandom_range(1, 100);
                1: dw = $urandom_range(1, 1000000);
                default: dw = $urandom | 32'd1;
            endcase
            case ($urandom_range(0, 9))
                0: di = 0;
                1: di = dw;
                default: di = $urandom_range(0, dw);
            endcase
        end
        k = $urandom_range(0, DEPTH - 2);
        case ($urandom_range(0, 9))
            0, 1, 2: cur = plan_freq[k];
            3: cur = plan_freq[k] + 1'b1;
            4, 5: cur = FREQ_W'($urandom);
            6: cur = '0;
            7: cur = FREQ_TOP;
            default: cur = FREQ_W'((32'(plan_freq[k]) + 32'(plan_freq[k + 1])) / 2);
        endcase
        push_interval(64'(dw), 64'(di), cur);
    endtask

    // ascending table, biased toward reachable targets and the limits
    task automatic push_sorted_table();
        int unsigned f [$];
        int unsigned scale;
        scale = 32'(plan_max) / 100;
        repeat (DEPTH) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: f.push_back($urandom_range(0, FREQ_TOP));
                17, 18: f.push_back(32'(plan_min));
                19: f.push_back(32'(plan_max));
                default: f.push_back($urandom_range(0, 100) * scale);
            endcase
        end
        f.sort();
        for (int k = 0; k < DEPTH; k++) begin
            push_entry(4'(k), FREQ_W'(f[k]), $urandom_range(0, 5) != 0);
        end
    endtask

    // wait for every outstanding result, then a little slack
    task automatic settle();
        while (results_seen < items_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write, valid left high for the next one
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_FREQ: lim_min = val;
            CFG_MAX_FREQ: lim_max = val;
            CFG_TABLE_LEN: walk_len = val[TLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [FREQ_W-1:0] lo_khz,
                                input logic [FREQ_W-1:0] hi_khz,
                                input logic [FREQ_W-1:0] len_word);
        cfg_put(CFG_MIN_FREQ, lo_khz);
        cfg_put(CFG_MAX_FREQ, hi_khz);
        cfg_put(CFG_TABLE_LEN, len_word);
        i_cfg_valid <= 1'b0;
        plan_min = lo_khz;
        plan_max = hi_khz;
    endtask

    // one setting: fresh table, then mostly samples with some stray writes
    task automatic run_phase(input logic [FREQ_W-1:0] lo_khz, input logic [FREQ_W-1:0] hi_khz,
                             input logic [FREQ_W-1:0] len_word, input int unsigned count);
        settle();
        program_regs(lo_khz, hi_khz, len_word);
        push_sorted_table();
        repeat (count - DEPTH) begin
            if ($urandom_range(0, 11) == 0)
                push_entry(4'($urandom), FREQ_W'($urandom), 1'($urandom));
            else
                push_random_sample();
        end
    endtask

    // stimulus sequence
    initial begin
        for (int k = 0; k < DEPTH; k++) begin
            tbl_freq[k] = '0;
            tbl_valid[k] = 1'b0;
            plan_freq[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config, empty walk: zero wall delta, wall below idle, load of 100
        push_interval(0, 0, '0);
        push_interval(1000, 2000, '0);
        push_interval(1000, 0, '0);
        // ascending table, zero entry at the bottom, one invalid slot, top at the maximum
        for (int k = 0; k < DEPTH; k++) begin
            push_entry(4'(k), (k == 8) ? FREQ_W'(2097150) :
                       (k == 15) ? FREQ_TOP : FREQ_W'(k * 260000), k != 3);
        end
        settle();
        program_regs('0, FREQ_TOP, FREQ_W'(DEPTH));
        push_interval(1000, 500, FREQ_W'(1820000));   // exact match
        push_interval(1000, 1000, FREQ_W'(500000));   // load 0 matches the zero entry
        push_interval(1000, 750, FREQ_W'(1100000));   // current kept between neighbors
        push_interval(1000, 750, FREQ_W'(2000000));   // entry above taken
        push_interval(1000, 0, '0);                    // full load, top entry
        wall_acc = 64'hFFFF_FFFF_FFFF_FF00;
        idle_acc = 64'hFFFF_FFFF_FFFF_FFC0;
        push_interval(0, 0, FREQ_TOP);                 // counter jump
        push_interval(64'h200, 64'h80, FREQ_TOP);      // 64-bit wrap of both totals
        push_interval(64'h1_0000_0000, 5, '0);         // delta only above bit 31
        settle();
        // min above max, table length past the depth
        program_regs(FREQ_W'(3000000), FREQ_W'(1000000), FREQ_TOP);
        push_interval(1000, 200, FREQ_W'(600000));

        // random settings, extremes first
        run_phase('0, FREQ_TOP, FREQ_W'(DEPTH), 140);
        run_phase('0, '0, FREQ_W'(DEPTH), 140);
        run_phase(FREQ_TOP, FREQ_TOP, FREQ_W'(DEPTH), 140);
        run_phase(FREQ_W'($urandom_range(2000000, FREQ_TOP)),
                  FREQ_W'($urandom_range(0, 1999999)), FREQ_W'(DEPTH), 140);
        run_phase('0, FREQ_W'(99), FREQ_W'(DEPTH), 140);
        run_phase('0, FREQ_TOP, '0, 140);
        run_phase(FREQ_W'(300000), FREQ_W'(3500000), FREQ_W'(1), 140);
        run_phase(FREQ_W'($urandom_range(0, 1000000)), FREQ_W'($urandom_range(1000000, FREQ_TOP)),
                  FREQ_W'(($urandom & 32'h3FFFE0) | $urandom_range(17, 31)), 140);
        repeat (3) begin
            run_phase(FREQ_W'($urandom_range(0, 1500000)),
                      FREQ_W'($urandom_range(1500000, FREQ_TOP)),
                      FREQ_W'($urandom_range(0, 31)), 140);
        end
        settle();
        calm = 1'b1;
        run_phase(FREQ_W'(200000), FREQ_TOP, FREQ_W'(DEPTH), 140);

        // drain and let the block go quiet
        settle();
        repeat (40) @(posedge i_clk);
        if (selections_due.size() != 0) begin
            $error("%0d results never arrived", selections_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: load_based_frequency_selector_core.f
rtl/core/lbfs_pkg.sv
rtl/core/lbfs_table_mem.sv
rtl/core/lbfs_load_div.sv
rtl/core/load_based_frequency_selector_core.sv
test/testbench.sv
